// ----- rtl/core/dels_pkg.sv -----
// Shared constants, codes and types of the double-ended list store.
package dels_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned IDX_W    = ADDR_W + 1;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;

  // Link value that points nowhere.
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(DEPTH);

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND_TAIL  = 3'd0,
    REQ_REMOVE_TAIL  = 3'd1,
    REQ_PREPEND_HEAD = 3'd2,
    REQ_REMOVE_HEAD  = 3'd3,
    REQ_DELETE_MATCH = 3'd4
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic              alloc;
    logic              release_en;
    logic [ADDR_W-1:0] release_idx;
  } free_ctrl_t;

  typedef struct packed {
    logic              any_free;
    logic [ADDR_W-1:0] alloc_idx;
  } free_stat_t;

endpackage

// ----- rtl/core/dels_req_if.sv -----
// Request channel: valid/ready handshake with request kind and value.
interface dels_req_if;
  logic                             valid;
  logic                             ready;
  logic [dels_pkg::REQ_W-1:0]       req_type;
  logic signed [dels_pkg::DATA_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

// ----- rtl/core/dels_rsp_if.sv -----
// Result channel: valid/ready handshake with removed value, count and status.
interface dels_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [dels_pkg::DATA_W-1:0] removed_value;
  logic [dels_pkg::CNT_W-1:0]         entry_count;
  logic [dels_pkg::STATUS_W-1:0]      status;

  modport source (output valid, removed_value, entry_count, status, input ready);
  modport sink   (input valid, removed_value, entry_count, status, output ready);
endinterface

// ----- rtl/core/dels_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module dels_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dels_free_map.sv -----
// Free-slot bitmap with lowest-free-slot allocator.
module dels_free_map (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dels_pkg::free_ctrl_t ctrl_i,
  output dels_pkg::free_stat_t stat_o
);
  import dels_pkg::*;

  logic [DEPTH-1:0]  free_q, free_d;
  logic [ADDR_W-1:0] low_idx;

  // Lowest set bit wins.
  always_comb begin
    low_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        low_idx = ADDR_W'(i);
      end
    end
  end

  assign stat_o.any_free  = |free_q;
  assign stat_o.alloc_idx = low_idx;

  always_comb begin
    free_d = free_q;
    if (ctrl_i.alloc) begin
      free_d[low_idx] = 1'b0;
    end
    if (ctrl_i.release_en) begin
      free_d[ctrl_i.release_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
    end else begin
      free_q <= free_d;
    end
  end

endmodule

// ----- rtl/core/double_ended_list_store.sv -----
// An end operation's request passes from the idle state through the execute state to the result register.
// A delete stays in the execute state while it steps past entries (one slot RAM read each).
// No new request is taken until the current one is done; the slot RAM read comes before the update.
// A waiting result holds off the next request until the cycle of its own transaction.
// Reset: list empty, every slot free, no clearing pass; slot RAMs are not reset.
module double_ended_list_store (
  input  logic       clk_i,
  input  logic       rst_ni,
  dels_req_if.sink   req_i,
  dels_rsp_if.source rsp_o
);
  import dels_pkg::*;

  state_e            state_q, state_d;
  req_type_e         req_q, req_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_value_q, out_value_d;
  logic [CNT_W-1:0]    out_count_q, out_count_d;
  status_e             out_status_q, out_status_d;

  logic in_fire;
  logic [ADDR_W-1:0] rd_addr;

  logic              dw_en;
  logic [ADDR_W-1:0] dw_addr;
  logic              fw_en, bw_en;
  logic [ADDR_W-1:0] fw_addr, bw_addr;
  logic [IDX_W-1:0]  fw_data, bw_data;
  logic [DATA_W-1:0] data_rd;
  logic [IDX_W-1:0]  fwd_rd, bwd_rd;

  logic [IDX_W-1:0] prev_idx, next_idx, new_idx;
  logic             cur_valid;
  req_type_e        in_req;

  free_ctrl_t free_ctrl;
  free_stat_t free_stat;

  assign in_req      = req_type_e'(req_i.req_type);
  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign in_fire     = req_i.valid && req_i.ready;

  // Neighbors of the current slot; head and tail ends never trust stored links.
  assign cur_valid = (cur_q != NULL_IDX);
  assign prev_idx  = (cur_q == head_q) ? NULL_IDX : bwd_rd;
  assign next_idx  = (cur_q == tail_q) ? NULL_IDX : fwd_rd;
  assign new_idx   = {1'b0, free_stat.alloc_idx};

  dels_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dw_en),
    .waddr_i (dw_addr),
    .wdata_i (val_q),
    .raddr_i (rd_addr),
    .rdata_o (data_rd)
  );

  dels_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fw_en),
    .waddr_i (fw_addr),
    .wdata_i (fw_data),
    .raddr_i (rd_addr),
    .rdata_o (fwd_rd)
  );

  dels_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_bwd_ram (
    .clk_i   (clk_i),
    .we_i    (bw_en),
    .waddr_i (bw_addr),
    .wdata_i (bw_data),
    .raddr_i (rd_addr),
    .rdata_o (bwd_rd)
  );

  dels_free_map u_free_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (free_ctrl),
    .stat_o (free_stat)
  );

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    val_d        = val_q;
    cur_d        = cur_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    dw_en        = 1'b0;
    dw_addr      = free_stat.alloc_idx;
    fw_en        = 1'b0;
    fw_addr      = '0;
    fw_data      = NULL_IDX;
    bw_en        = 1'b0;
    bw_addr      = '0;
    bw_data      = NULL_IDX;
    free_ctrl    = '0;
    rd_addr      = '0;

    case (state_q)
      S_IDLE: begin
        // Start reading the end slot the request works on.
        rd_addr = (in_req == REQ_REMOVE_TAIL) ? tail_q[ADDR_W-1:0] : head_q[ADDR_W-1:0];
        if (in_fire) begin
          req_d   = in_req;
          val_d   = req_i.value;
          cur_d   = (in_req == REQ_REMOVE_TAIL) ? tail_q : head_q;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_addr      = next_idx[ADDR_W-1:0];
        state_d      = S_IDLE;
        out_valid_d  = 1'b1;
        out_value_d  = '0;
        out_status_d = ST_OK;
        case (req_q)
          REQ_APPEND_TAIL, REQ_PREPEND_HEAD: begin
            if (!free_stat.any_free) begin
              out_status_d = ST_FULL;
            end else begin
              dw_en           = 1'b1;
              free_ctrl.alloc = 1'b1;
              count_d         = count_q + 1'b1;
              if (req_q == REQ_APPEND_TAIL) begin
                bw_en   = 1'b1;
                bw_addr = free_stat.alloc_idx;
                bw_data = tail_q;
                if (tail_q != NULL_IDX) begin
                  fw_en   = 1'b1;
                  fw_addr = tail_q[ADDR_W-1:0];
                  fw_data = new_idx;
                end else begin
                  head_d = new_idx;
                end
                tail_d = new_idx;
              end else begin
                fw_en   = 1'b1;
                fw_addr = free_stat.alloc_idx;
                fw_data = head_q;
                if (head_q != NULL_IDX) begin
                  bw_en   = 1'b1;
                  bw_addr = head_q[ADDR_W-1:0];
                  bw_data = new_idx;
                end else begin
                  tail_d = new_idx;
                end
                head_d = new_idx;
              end
            end
          end
          REQ_REMOVE_TAIL, REQ_REMOVE_HEAD, REQ_DELETE_MATCH: begin
            if (!cur_valid) begin
              out_status_d = (req_q == REQ_DELETE_MATCH) ? ST_NOT_FOUND : ST_EMPTY;
            end else if (req_q == REQ_DELETE_MATCH && data_rd != val_q) begin
              // Advance the walk; hold the result back.
              cur_d       = next_idx;
              state_d     = S_EXEC;
              out_valid_d = out_valid_q && !rsp_o.ready;
            end else begin
              if (req_q != REQ_DELETE_MATCH) begin
                out_value_d = data_rd;
              end
              if (prev_idx != NULL_IDX) begin
                fw_en   = 1'b1;
                fw_addr = prev_idx[ADDR_W-1:0];
                fw_data = next_idx;
              end else begin
                head_d = next_idx;
              end
              if (next_idx != NULL_IDX) begin
                bw_en   = 1'b1;
                bw_addr = next_idx[ADDR_W-1:0];
                bw_data = prev_idx;
              end else begin
                tail_d = prev_idx;
              end
              free_ctrl.release_en  = 1'b1;
              free_ctrl.release_idx = cur_q[ADDR_W-1:0];
              count_d               = count_q - 1'b1;
            end
          end
          default: begin
          end
        endcase
        out_count_d = count_d;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NULL_IDX;
      tail_q      <= NULL_IDX;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    val_q        <= val_d;
    cur_q        <= cur_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.removed_value = out_value_q;
  assign rsp_o.entry_count   = out_count_q;
  assign rsp_o.status        = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above store depth");

  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NULL_IDX) == (count_q == '0))
    else $error("head pointer disagrees with entry count");

  a_tail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q == NULL_IDX) == (count_q == '0))
    else $error("tail pointer disagrees with entry count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_FULL) |-> out_count_q == CNT_W'(DEPTH))
    else $error("full status reported below depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_EMPTY) |-> out_count_q == '0)
    else $error("empty status reported with entries held");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the double-ended list store: directed and random request traffic vs a queue model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dels_pkg::*;

  localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 3'd5;
  localparam logic [REQ_W-1:0] REQ_LAST_CODE    = 3'd7;
  localparam int RANDOM_ITEMS = 1980;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLDOFF_LEN  = 200;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [REQ_W-1:0]         kind;
    logic signed [DATA_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed;
    logic [CNT_W-1:0]         count;
    status_e                  status;
  } list_rsp_t;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  dels_req_if req_if ();
  dels_rsp_if rsp_if ();

  double_ended_list_store DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  list_req_t                req_backlog[$];
  list_rsp_t                rsp_due[$];
  logic signed [DATA_W-1:0] model_entries[$];
  logic signed [DATA_W-1:0] gen_entries[$];

  int send_idle_pct = 34;
  int recv_idle_pct = 70;
  int accepted_cnt  = 0;
  int rsp_checked   = 0;
  int holdoff_left  = 0;
  int holdoff_done  = 0;
  int mismatches    = 0;
  int cycle_cnt     = 0;

  // Apply one request to a list of values, head at index 0, and return its result.
  function automatic void deque_apply(ref logic signed [DATA_W-1:0] entries[$],
                                      input list_req_t rq, output list_rsp_t rs);
    int idx;
    rs.removed = '0;
    rs.status  = ST_OK;
    case (rq.kind)
      REQ_APPEND_TAIL, REQ_PREPEND_HEAD: begin
        if (entries.size() >= DEPTH) begin
          rs.status = ST_FULL;
        end else if (rq.kind == REQ_APPEND_TAIL) begin
          entries.push_back(rq.value);
        end else begin
          entries.push_front(rq.value);
        end
      end
      REQ_REMOVE_TAIL, REQ_REMOVE_HEAD: begin
        if (entries.size() == 0) begin
          rs.status = ST_EMPTY;
        end else if (rq.kind == REQ_REMOVE_TAIL) begin
          rs.removed = entries.pop_back();
        end else begin
          rs.removed = entries.pop_front();
        end
      end
      REQ_DELETE_MATCH: begin
        rs.status = ST_NOT_FOUND;
        for (idx = 0; idx < entries.size(); idx++) begin
          if (entries[idx] == rq.value) begin
            entries.delete(idx);
            rs.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    rs.count = CNT_W'(entries.size());
  endfunction

  // Queue a request and track the list contents it leaves, to aim later deletes.
  function automatic void queue_req(input logic [REQ_W-1:0] kind,
                                    input logic signed [DATA_W-1:0] v);
    list_req_t rq;
    list_rsp_t unused_rs;
    rq.kind  = kind;
    rq.value = v;
    deque_apply(gen_entries, rq, unused_rs);
    req_backlog.push_back(rq);
  endfunction

  // Favor a few small values and the extremes so duplicates and matches are common.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = DATA_W'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '1;
          default: v = '0;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Driver: present backlog items, predict each one at its transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    list_req_t cur;
    list_rsp_t res;
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.req_type <= REQ_APPEND_TAIL;
      req_if.value    <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        cur.kind  = req_if.req_type;
        cur.value = req_if.value;
        deque_apply(model_entries, cur, res);
        rsp_due.push_back(res);
        accepted_cnt++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur = req_backlog.pop_front();
          req_if.valid    <= 1'b1;
          req_if.req_type <= cur.kind;
          req_if.value    <= cur.value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    list_rsp_t exp_rs;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_due.size() == 0) begin
          $error("result with nothing outstanding: removed %0d count %0d status %0d",
                 rsp_if.removed_value, rsp_if.entry_count, rsp_if.status);
          mismatches++;
        end else begin
          exp_rs = rsp_due.pop_front();
          if (rsp_if.removed_value !== exp_rs.removed) begin
            $error("removed_value: expected %0d, got %0d", exp_rs.removed,
                   rsp_if.removed_value);
            mismatches++;
          end
          if (rsp_if.entry_count !== exp_rs.count) begin
            $error("entry_count: expected %0d, got %0d", exp_rs.count, rsp_if.entry_count);
            mismatches++;
          end
          if (rsp_if.status !== exp_rs.status) begin
            $error("status: expected %0d, got %0d", exp_rs.status, rsp_if.status);
            mismatches++;
          end
        end
        rsp_checked++;
      end
      if (holdoff_left > 0) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Stall the output long enough to back the block up into its input; count the stall here.
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
    end else if ((holdoff_done == 0 && rsp_checked >= 400) ||
                 (holdoff_done == 1 && rsp_checked >= 1500)) begin
      holdoff_left = HOLDOFF_LEN;
      holdoff_done++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int total;
    int n;
    int k;
    int roll;
    int add_pct;
    int burst_left;
    burst_e mode;

    req_if.valid    = 1'b0;
    req_if.req_type = REQ_APPEND_TAIL;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;
    rst_ni          = 1'b0;

    // Empty list: removals, a delete and the unused codes.
    queue_req(REQ_REMOVE_TAIL, 32'sd99);
    queue_req(REQ_REMOVE_HEAD, '1);
    queue_req(REQ_DELETE_MATCH, '0);
    for (k = REQ_FIRST_UNUSED; k <= REQ_LAST_CODE; k++) queue_req(REQ_W'(k), $urandom());
    // Extremes at both ends, then delete from the middle and miss.
    queue_req(REQ_APPEND_TAIL, 32'sh7FFF_FFFF);
    queue_req(REQ_PREPEND_HEAD, 32'sh8000_0000);
    queue_req(REQ_APPEND_TAIL, '0);
    queue_req(REQ_APPEND_TAIL, '1);
    queue_req(REQ_DELETE_MATCH, '0);
    queue_req(REQ_DELETE_MATCH, 32'sd123);
    queue_req(REQ_FIRST_UNUSED, 32'sd5);
    queue_req(REQ_REMOVE_HEAD, '0);
    queue_req(REQ_REMOVE_TAIL, '0);
    // Duplicates: delete takes the one nearest the head.
    queue_req(REQ_PREPEND_HEAD, 32'sd5);
    queue_req(REQ_APPEND_TAIL, 32'sd5);
    queue_req(REQ_DELETE_MATCH, 32'sd5);
    queue_req(REQ_REMOVE_HEAD, '0);
    queue_req(REQ_REMOVE_TAIL, '0);
    queue_req(REQ_REMOVE_TAIL, '0);

    // Bursts biased to fill or drain so the list swings between empty and full.
    burst_left = 0;
    mode = BURST_MIXED;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        mode = burst_e'($urandom_range(BURST_FILL, BURST_MIXED));
        burst_left = $urandom_range(20, 100);
      end
      burst_left--;
      case (mode)
        BURST_FILL:  add_pct = 65;
        BURST_DRAIN: add_pct = 15;
        default:     add_pct = 40;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        queue_req(REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE)), $urandom());
      end else if (roll < 18) begin
        if (gen_entries.size() != 0 && $urandom_range(0, 1) == 1)
          queue_req(REQ_DELETE_MATCH, gen_entries[$urandom_range(0, gen_entries.size() - 1)]);
        else
          queue_req(REQ_DELETE_MATCH, pick_value());
      end else if (roll < 18 + add_pct) begin
        queue_req($urandom_range(0, 1) ? REQ_APPEND_TAIL : REQ_PREPEND_HEAD, pick_value());
      end else begin
        queue_req($urandom_range(0, 1) ? REQ_REMOVE_TAIL : REQ_REMOVE_HEAD, $urandom());
      end
    end
    total = req_backlog.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cnt >= total / 3);
    send_idle_pct <= 70;
    recv_idle_pct <= 34;
    wait (accepted_cnt >= 2 * total / 3);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    wait (accepted_cnt == total);

    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
